// ===== src/fipv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fipv_pkg
// Shared types, codes and reset values for the firmware image parser/checker.
// ----------------------------------------------------------------------------
package fipv_pkg;

    // default trailer slot size in bytes
    localparam int TRAILER_ALIGN_DEF = 16;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_HEADER_MAGIC  = 2'd0;
    localparam logic [1:0] REG_CHECKSUM_SEED = 2'd1;
    localparam logic [1:0] REG_CODE_BASE     = 2'd2;
    localparam logic [1:0] REG_DATA_BASE     = 2'd3;

    localparam logic [7:0]  HEADER_MAGIC_RST  = 8'hE9;
    localparam logic [7:0]  CHECKSUM_SEED_RST = 8'hEF;
    localparam logic [31:0] CODE_BASE_RST     = 32'h4010_0000;
    localparam logic [31:0] DATA_BASE_RST     = 32'h3FFE_8000;

    // parse phases
    localparam logic [2:0] PH_FILEHDR = 3'd0;
    localparam logic [2:0] PH_SECHDR  = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_PAD     = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    // record kinds
    localparam logic KIND_SECTION = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // region classes
    localparam logic [1:0] CLASS_CODE  = 2'd0;
    localparam logic [1:0] CLASS_DATA  = 2'd1;
    localparam logic [1:0] CLASS_OTHER = 2'd2;

    // final status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_NO_SECT   = 3'd2;
    localparam logic [2:0] ST_BAD_PAD   = 3'd3;
    localparam logic [2:0] ST_BAD_CSUM  = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;
    localparam logic [2:0] ST_OVERFLOW  = 3'd6;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_image;
    } in_beat_t;

    typedef struct packed {
        logic        record_kind;
        logic [7:0]  section_number;
        logic [31:0] load_address;
        logic [31:0] section_length;
        logic [31:0] data_offset;
        logic [1:0]  region_class;
        logic        first_of_class;
        logic [2:0]  status_code;
        logic [31:0] entry_address;
        logic [7:0]  computed_checksum;
        logic [7:0]  stored_checksum;
    } out_beat_t;

    typedef struct packed {
        logic [7:0]  header_magic;
        logic [7:0]  checksum_seed;
        logic [31:0] code_region_base;
        logic [31:0] data_region_base;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [2:0]  field_cnt;
        logic [7:0]  sec_left;
        logic [7:0]  cur_sec;
        logic [31:0] file_pos;
        logic [31:0] data_left;
        logic [7:0]  csum;
        logic [31:0] addr_sh;
        logic [31:0] len_sh;
        logic [31:0] start_addr;
        logic [1:0]  classes;
    } parse_state_t;

    localparam parse_state_t STATE_RST = '{
        phase:      PH_FILEHDR,
        field_cnt:  3'd0,
        sec_left:   8'd0,
        cur_sec:    8'd0,
        file_pos:   32'd0,
        data_left:  32'd0,
        csum:       CHECKSUM_SEED_RST,
        addr_sh:    32'd0,
        len_sh:     32'd0,
        start_addr: 32'd0,
        classes:    2'd0
    };

endpackage

// ===== src/fipv_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fipv_cfg_regs
// APB register file: header magic, checksum seed and the two region bases.
// ----------------------------------------------------------------------------
module fipv_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fipv_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fipv_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fipv_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output fipv_pkg::cfg_t                      cfg
);

    fipv_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_magic     <= fipv_pkg::HEADER_MAGIC_RST;
            cfg_reg.checksum_seed    <= fipv_pkg::CHECKSUM_SEED_RST;
            cfg_reg.code_region_base <= fipv_pkg::CODE_BASE_RST;
            cfg_reg.data_region_base <= fipv_pkg::DATA_BASE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                fipv_pkg::REG_HEADER_MAGIC:  cfg_reg.header_magic     <= pwdata[7:0];
                fipv_pkg::REG_CHECKSUM_SEED: cfg_reg.checksum_seed    <= pwdata[7:0];
                fipv_pkg::REG_CODE_BASE:     cfg_reg.code_region_base <= pwdata;
                fipv_pkg::REG_DATA_BASE:     cfg_reg.data_region_base <= pwdata;
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        unique case (reg_idx)
            fipv_pkg::REG_HEADER_MAGIC:  prdata = {24'd0, cfg_reg.header_magic};
            fipv_pkg::REG_CHECKSUM_SEED: prdata = {24'd0, cfg_reg.checksum_seed};
            fipv_pkg::REG_CODE_BASE:     prdata = cfg_reg.code_region_base;
            fipv_pkg::REG_DATA_BASE:     prdata = cfg_reg.data_region_base;
            default:                     prdata = '0;
        endcase
    end

endmodule

// ===== src/fipv_parse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fipv_parse_core
// Next-state and result logic for one image byte or end marker.
// ----------------------------------------------------------------------------
module fipv_parse_core #(
    parameter int TRAILER_ALIGN = fipv_pkg::TRAILER_ALIGN_DEF,
    localparam int SLOT_W = $clog2(TRAILER_ALIGN)
) (
    input  fipv_pkg::parse_state_t  st,
    input  logic [SLOT_W-1:0]       slot,
    input  fipv_pkg::in_beat_t      beat,
    input  fipv_pkg::cfg_t          cfg,
    output fipv_pkg::parse_state_t  st_next,
    output logic [SLOT_W-1:0]       slot_next,
    output logic                    res_valid,
    output fipv_pkg::out_beat_t     res
);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TRAILER_ALIGN - 1);

    // final status record from the current state
    function automatic fipv_pkg::out_beat_t status_rec(input fipv_pkg::parse_state_t s,
                                                       input logic [2:0] code,
                                                       input logic [7:0] stored);
        fipv_pkg::out_beat_t r;
        r                   = '0;
        r.record_kind       = fipv_pkg::KIND_STATUS;
        r.section_number    = s.cur_sec;
        r.status_code       = code;
        r.entry_address     = s.start_addr;
        r.computed_checksum = s.csum;
        r.stored_checksum   = stored;
        return r;
    endfunction

    logic [7:0]        b;
    logic [2:0]        k;
    logic [31:0]       pos_inc;
    logic [SLOT_W-1:0] slot_inc;
    logic [31:0]       addr_new;
    logic [31:0]       len_new;
    logic [31:0]       left_dec;
    logic [7:0]        sec_dec;
    logic [31:0]       pad_len;
    logic [1:0]        cls;
    logic              first;
    logic              is_code;
    logic              is_data;

    assign b        = beat.byte_value;
    assign k        = st.field_cnt;
    assign pos_inc  = st.file_pos + 32'd1;
    assign slot_inc = (slot == SLOT_LAST) ? '0 : slot + SLOT_W'(1);
    assign addr_new = (k < 3'd4) ? {b, st.addr_sh[31:8]} : st.addr_sh;
    assign len_new  = (k < 3'd4) ? st.len_sh : {b, st.len_sh[31:8]};
    assign left_dec = st.data_left - 32'd1;
    assign sec_dec  = st.sec_left - 8'd1;
    // bytes to skip before the checksum slot, counted from the new position
    assign pad_len  = 32'(SLOT_LAST) - 32'(slot_inc);

    // region classification of the completed section header
    assign is_code = st.addr_sh >= cfg.code_region_base;
    assign is_data = st.addr_sh >= cfg.data_region_base;
    always_comb begin
        priority if (is_code) begin
            cls   = fipv_pkg::CLASS_CODE;
            first = !st.classes[0];
        end else if (is_data) begin
            cls   = fipv_pkg::CLASS_DATA;
            first = !st.classes[1];
        end else begin
            cls   = fipv_pkg::CLASS_OTHER;
            first = 1'b0;
        end
    end

    // one byte step
    always_comb begin
        st_next   = st;
        slot_next = slot;
        res_valid = 1'b0;
        res       = '0;
        priority if (beat.end_of_image) begin
            // end marker: truncated unless already finished, then restart
            if (st.phase != fipv_pkg::PH_DONE) begin
                res_valid = 1'b1;
                res       = status_rec(st, fipv_pkg::ST_TRUNC, 8'd0);
            end
            st_next      = fipv_pkg::STATE_RST;
            st_next.csum = cfg.checksum_seed;
            slot_next    = '0;
        end else if (st.phase == fipv_pkg::PH_DONE) begin
            // trailing bytes ignored
        end else if (st.file_pos == 32'hFFFF_FFFF) begin
            res_valid     = 1'b1;
            res           = status_rec(st, fipv_pkg::ST_OVERFLOW, 8'd0);
            st_next.phase = fipv_pkg::PH_DONE;
        end else begin
            st_next.file_pos = pos_inc;
            slot_next        = slot_inc;
            unique case (st.phase)
                fipv_pkg::PH_FILEHDR: begin
                    priority if (k == 3'd0 && b != cfg.header_magic) begin
                        res_valid     = 1'b1;
                        res           = status_rec(st, fipv_pkg::ST_BAD_MAGIC, 8'd0);
                        st_next.phase = fipv_pkg::PH_DONE;
                    end else if (k == 3'd1 && b == 8'd0) begin
                        res_valid     = 1'b1;
                        res           = status_rec(st, fipv_pkg::ST_NO_SECT, 8'd0);
                        st_next.phase = fipv_pkg::PH_DONE;
                    end else if ((k == 3'd2 || k == 3'd3) && b != 8'd0) begin
                        res_valid     = 1'b1;
                        res           = status_rec(st, fipv_pkg::ST_BAD_PAD, 8'd0);
                        st_next.phase = fipv_pkg::PH_DONE;
                    end else begin
                        if (k == 3'd1) begin
                            st_next.sec_left = b;
                        end
                        if (k >= 3'd4) begin
                            st_next.start_addr = {b, st.start_addr[31:8]};
                        end
                        if (k == 3'd7) begin
                            st_next.field_cnt = 3'd0;
                            st_next.csum      = cfg.checksum_seed;
                            st_next.cur_sec   = 8'd0;
                            st_next.classes   = 2'd0;
                            st_next.phase     = fipv_pkg::PH_SECHDR;
                        end else begin
                            st_next.field_cnt = k + 3'd1;
                        end
                    end
                end
                fipv_pkg::PH_SECHDR: begin
                    st_next.addr_sh = addr_new;
                    st_next.len_sh  = len_new;
                    if (k != 3'd7) begin
                        st_next.field_cnt = k + 3'd1;
                    end else begin
                        // header complete: section record
                        res_valid          = 1'b1;
                        res.record_kind    = fipv_pkg::KIND_SECTION;
                        res.section_number = st.cur_sec;
                        res.load_address   = st.addr_sh;
                        res.section_length = len_new;
                        res.data_offset    = pos_inc;
                        res.region_class   = cls;
                        res.first_of_class = first;
                        st_next.field_cnt  = 3'd0;
                        if (cls == fipv_pkg::CLASS_CODE) begin
                            st_next.classes[0] = 1'b1;
                        end
                        if (cls == fipv_pkg::CLASS_DATA) begin
                            st_next.classes[1] = 1'b1;
                        end
                        st_next.cur_sec   = st.cur_sec + 8'd1;
                        st_next.sec_left  = sec_dec;
                        st_next.data_left = len_new;
                        priority if (len_new != 32'd0) begin
                            st_next.phase = fipv_pkg::PH_DATA;
                        end else if (sec_dec != 8'd0) begin
                            st_next.phase = fipv_pkg::PH_SECHDR;
                        end else if (slot_inc == SLOT_LAST) begin
                            st_next.phase = fipv_pkg::PH_CHECK;
                        end else begin
                            st_next.data_left = pad_len;
                            st_next.phase     = fipv_pkg::PH_PAD;
                        end
                    end
                end
                fipv_pkg::PH_DATA: begin
                    st_next.csum      = st.csum ^ b;
                    st_next.data_left = left_dec;
                    if (left_dec == 32'd0) begin
                        priority if (st.sec_left != 8'd0) begin
                            st_next.phase = fipv_pkg::PH_SECHDR;
                        end else if (slot_inc == SLOT_LAST) begin
                            st_next.phase = fipv_pkg::PH_CHECK;
                        end else begin
                            st_next.data_left = pad_len;
                            st_next.phase     = fipv_pkg::PH_PAD;
                        end
                    end
                end
                fipv_pkg::PH_PAD: begin
                    st_next.data_left = left_dec;
                    if (left_dec == 32'd0) begin
                        st_next.phase = fipv_pkg::PH_CHECK;
                    end
                end
                fipv_pkg::PH_CHECK: begin
                    res_valid     = 1'b1;
                    res           = status_rec(st, (b == st.csum) ? fipv_pkg::ST_OK
                                                                  : fipv_pkg::ST_BAD_CSUM, b);
                    st_next.phase = fipv_pkg::PH_DONE;
                end
                default: begin
                    st_next.phase = fipv_pkg::PH_DONE;
                end
            endcase
        end
    end

endmodule

// ===== src/firmware_image_parse_verify.sv =====
`timescale 1ns / 1ps
// Result path: a byte sits in the input register, and its result loads into the result
// register when that byte moves on; output back-pressure can hold the byte in between.
// Throughput: one byte per cycle; the per-byte step is a single pass of the
// parse core between the two registers, and stalls only on output back-pressure.
// Reset: synchronous, active low; parser returns to the file header phase and
// the configuration registers take their default values.
// ----------------------------------------------------------------------------
// firmware_image_parse_verify
// Streaming firmware image parser with section records and XOR checksum check.
// ----------------------------------------------------------------------------
module firmware_image_parse_verify #(
    parameter int TRAILER_ALIGN = fipv_pkg::TRAILER_ALIGN_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // image bytes
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fipv_pkg::in_beat_t                  s_payload,
    // records
    output logic                                m_valid,
    input  logic                                m_ready,
    output fipv_pkg::out_beat_t                 m_payload,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fipv_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fipv_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fipv_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int SLOT_W = $clog2(TRAILER_ALIGN);

    fipv_pkg::cfg_t         cfg;
    logic                   in_valid_reg;
    fipv_pkg::in_beat_t     in_beat_reg;
    fipv_pkg::parse_state_t state_reg;
    fipv_pkg::parse_state_t state_next;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SLOT_W-1:0]      slot_next;
    logic                   m_valid_reg;
    fipv_pkg::out_beat_t    out_beat_reg;
    logic                   res_valid;
    fipv_pkg::out_beat_t    res;
    logic                   advance;

    fipv_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fipv_parse_core #(
        .TRAILER_ALIGN (TRAILER_ALIGN)
    ) u_core (
        .st        (state_reg),
        .slot      (slot_reg),
        .beat      (in_beat_reg),
        .cfg       (cfg),
        .st_next   (state_next),
        .slot_next (slot_next),
        .res_valid (res_valid),
        .res       (res)
    );

    // the held beat moves on when the result register is free or draining
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_beat_reg;

    // control and parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= fipv_pkg::STATE_RST;
            slot_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= state_next;
                slot_reg  <= slot_next;
            end
            if (advance && res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_payload;
        end
        if (advance && res_valid) begin
            out_beat_reg <= res;
        end
    end

    // a status record always finishes the image
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_valid && res.record_kind == fipv_pkg::KIND_STATUS
            && !in_beat_reg.end_of_image |=> state_reg.phase == fipv_pkg::PH_DONE)
        else $error("status record did not finish the image");

    // class flags only accumulate within one image
    a_classes_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_beat_reg.end_of_image && state_reg.phase != fipv_pkg::PH_FILEHDR
            |=> (state_reg.classes & $past(state_reg.classes)) == $past(state_reg.classes))
        else $error("class flags cleared mid-image");

    // a stalled beat is held in the input register
    a_hold_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_beat_reg))
        else $error("stalled beat lost");

    // no record once the image is finished
    a_no_record_done: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && state_reg.phase == fipv_pkg::PH_DONE && !in_beat_reg.end_of_image
            |-> !res_valid)
        else $error("record produced after final status");

endmodule

// ===== verif/firmware_image_parse_verify_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firmware_image_parse_verify_tb
// Self-checking bench for the streaming firmware image parser. Images are
// generated as byte streams (mostly well-formed, with checksum faults,
// truncation, header faults, oversized sections and noise). They are driven
// over the valid/ready input with random gaps. Every record is predicted by an
// in-bench model of the parser and compared field by field. The configuration
// registers are reprogrammed between batches over APB and read back.
// ----------------------------------------------------------------------------
module firmware_image_parse_verify_tb;

    localparam int          TRAILER_SLOT      = fipv_pkg::TRAILER_ALIGN_DEF;
    localparam int          IDLE_SETTLE       = 4;
    localparam int          NUM_SETTINGS      = 6;
    localparam int unsigned BEATS_PER_SETTING = 200;

    // ------------------------------------------------------------------------
    // DUT connections; every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    fipv_pkg::in_beat_t              s_payload = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    fipv_pkg::out_beat_t             m_payload;
    logic                            psel      = 1'b0;
    logic                            penable   = 1'b0;
    logic                            pwrite    = 1'b0;
    logic [fipv_pkg::APB_ADDR_W-1:0] paddr     = '0;
    logic [fipv_pkg::APB_DATA_W-1:0] pwdata    = '0;
    logic [fipv_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    firmware_image_parse_verify #(
        .TRAILER_ALIGN (TRAILER_SLOT)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    fipv_pkg::cfg_t         live_cfg = {fipv_pkg::HEADER_MAGIC_RST, fipv_pkg::CHECKSUM_SEED_RST,
                                        fipv_pkg::CODE_BASE_RST, fipv_pkg::DATA_BASE_RST};
    fipv_pkg::parse_state_t parser   = fipv_pkg::STATE_RST;

    fipv_pkg::in_beat_t     image_bytes[$];       // beats waiting for the driver
    fipv_pkg::out_beat_t    expected_records[$];  // predicted records, oldest first
    logic [7:0]             image_draft[$];       // image under construction

    int unsigned  send_gap, take_hold;
    bit           send_burst, take_burst;
    int unsigned  mismatches, records_checked, sections_checked, statuses_checked;
    int unsigned  images_queued, items_queued;
    int unsigned  status_hits[8];

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h (record %0d)",
                                      name, got, want, records_checked));
    endtask

    // ------------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------------
    function automatic void reset_parser();
        parser      = fipv_pkg::STATE_RST;
        parser.csum = live_cfg.checksum_seed;
    endfunction

    function automatic void post_status(input logic [2:0] code, input logic [7:0] stored);
        fipv_pkg::out_beat_t rec;
        rec                   = '0;
        rec.record_kind       = fipv_pkg::KIND_STATUS;
        rec.section_number    = parser.cur_sec;
        rec.status_code       = code;
        rec.entry_address     = parser.start_addr;
        rec.computed_checksum = parser.csum;
        rec.stored_checksum   = stored;
        expected_records.push_back(rec);
        parser.phase = fipv_pkg::PH_DONE;
    endfunction

    // next section header, or skip to the checksum slot after the last one
    function automatic void close_section();
        logic [31:0] pad;
        if (parser.sec_left == 8'd0) begin
            pad = 32'(TRAILER_SLOT - 1) - (parser.file_pos % 32'(TRAILER_SLOT));
            if (pad == 32'd0) begin
                parser.phase = fipv_pkg::PH_CHECK;
            end else begin
                parser.data_left = pad;
                parser.phase     = fipv_pkg::PH_PAD;
            end
        end else begin
            parser.phase = fipv_pkg::PH_SECHDR;
        end
    endfunction

    function automatic void step_parser(input fipv_pkg::in_beat_t beat);
        logic [7:0]          b;
        logic [2:0]          k;
        fipv_pkg::out_beat_t rec;
        b = beat.byte_value;
        // end marker: truncation unless a final status already went out
        if (beat.end_of_image) begin
            if (parser.phase != fipv_pkg::PH_DONE)
                post_status(fipv_pkg::ST_TRUNC, 8'h00);
            reset_parser();
            return;
        end
        if (parser.phase == fipv_pkg::PH_DONE)
            return;
        // only reachable with a 4 GiB image
        if (parser.file_pos == 32'hFFFF_FFFF) begin
            post_status(fipv_pkg::ST_OVERFLOW, 8'h00);
            return;
        end
        parser.file_pos = parser.file_pos + 32'd1;
        k = parser.field_cnt;

        case (parser.phase)
            fipv_pkg::PH_FILEHDR: begin
                if (k == 3'd0 && b != live_cfg.header_magic) begin
                    post_status(fipv_pkg::ST_BAD_MAGIC, 8'h00);
                    return;
                end
                if (k == 3'd1) begin
                    if (b == 8'h00) begin
                        post_status(fipv_pkg::ST_NO_SECT, 8'h00);
                        return;
                    end
                    parser.sec_left = b;
                end
                if ((k == 3'd2 || k == 3'd3) && b != 8'h00) begin
                    post_status(fipv_pkg::ST_BAD_PAD, 8'h00);
                    return;
                end
                if (k >= 3'd4)
                    parser.start_addr = {b, parser.start_addr[31:8]};
                if (k == 3'd7) begin
                    parser.field_cnt = 3'd0;
                    parser.csum      = live_cfg.checksum_seed;
                    parser.cur_sec   = 8'd0;
                    parser.classes   = 2'b00;
                    parser.phase     = fipv_pkg::PH_SECHDR;
                end else begin
                    parser.field_cnt = k + 3'd1;
                end
            end
            fipv_pkg::PH_SECHDR: begin
                if (k < 3'd4)
                    parser.addr_sh = {b, parser.addr_sh[31:8]};
                else
                    parser.len_sh = {b, parser.len_sh[31:8]};
                if (k != 3'd7) begin
                    parser.field_cnt = k + 3'd1;
                    return;
                end
                parser.field_cnt = 3'd0;
                rec                = '0;
                rec.record_kind    = fipv_pkg::KIND_SECTION;
                rec.section_number = parser.cur_sec;
                rec.load_address   = parser.addr_sh;
                rec.section_length = parser.len_sh;
                rec.data_offset    = parser.file_pos;
                rec.region_class   = fipv_pkg::CLASS_OTHER;
                // first-of-class flag only for code and data
                if (parser.addr_sh >= live_cfg.code_region_base) begin
                    rec.region_class   = fipv_pkg::CLASS_CODE;
                    rec.first_of_class = !parser.classes[0];
                    parser.classes[0]  = 1'b1;
                end else if (parser.addr_sh >= live_cfg.data_region_base) begin
                    rec.region_class   = fipv_pkg::CLASS_DATA;
                    rec.first_of_class = !parser.classes[1];
                    parser.classes[1]  = 1'b1;
                end
                expected_records.push_back(rec);
                parser.cur_sec   = parser.cur_sec + 8'd1;
                parser.sec_left  = parser.sec_left - 8'd1;
                parser.data_left = parser.len_sh;
                if (parser.data_left == 32'd0)
                    close_section();
                else
                    parser.phase = fipv_pkg::PH_DATA;
            end
            fipv_pkg::PH_DATA: begin
                parser.csum      = parser.csum ^ b;
                parser.data_left = parser.data_left - 32'd1;
                if (parser.data_left == 32'd0)
                    close_section();
            end
            fipv_pkg::PH_PAD: begin
                parser.data_left = parser.data_left - 32'd1;
                if (parser.data_left == 32'd0)
                    parser.phase = fipv_pkg::PH_CHECK;
            end
            fipv_pkg::PH_CHECK: begin
                post_status((b == parser.csum) ? fipv_pkg::ST_OK : fipv_pkg::ST_BAD_CSUM, b);
            end
            default: begin
                parser.phase = fipv_pkg::PH_DONE;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Record checking
    // ------------------------------------------------------------------------
    task automatic compare_record(input fipv_pkg::out_beat_t got);
        fipv_pkg::out_beat_t want;
        if (expected_records.size() == 0) begin
            report_mismatch($sformatf("record with none expected: kind %0d section %0d %s %0d",
                                      got.record_kind, got.section_number, "status",
                                      got.status_code));
            return;
        end
        want = expected_records.pop_front();
        compare_field("record_kind",       32'(got.record_kind),    32'(want.record_kind));
        compare_field("section_number",    32'(got.section_number), 32'(want.section_number));
        compare_field("load_address",      got.load_address,        want.load_address);
        compare_field("section_length",    got.section_length,      want.section_length);
        compare_field("data_offset",       got.data_offset,         want.data_offset);
        compare_field("region_class",      32'(got.region_class),   32'(want.region_class));
        compare_field("first_of_class",    32'(got.first_of_class), 32'(want.first_of_class));
        compare_field("status_code",       32'(got.status_code),    32'(want.status_code));
        compare_field("entry_address",     got.entry_address,       want.entry_address);
        compare_field("computed_checksum", 32'(got.computed_checksum),
                      32'(want.computed_checksum));
        compare_field("stored_checksum",   32'(got.stored_checksum),
                      32'(want.stored_checksum));
        records_checked++;
        if (want.record_kind == fipv_pkg::KIND_STATUS) begin
            statuses_checked++;
            status_hits[want.status_code]++;
        end else begin
            sections_checked++;
        end
    endtask

    function automatic int unsigned draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 10);
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: one beat per handshake, random gap after each
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : image_driver
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                step_parser(s_payload);
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (image_bytes.size() != 0) begin
                    s_payload <= image_bytes.pop_front();
                    s_valid   <= 1'b1;
                    send_gap  <= draw_wait(send_burst);
                    if ($urandom_range(0, 39) == 0)
                        send_burst <= !send_burst;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: random back-pressure after each beat
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : record_monitor
        int unsigned hold;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            take_hold <= 0;
        end else if (m_valid && m_ready) begin
            compare_record(m_payload);
            hold = draw_wait(take_burst);
            if ($urandom_range(0, 39) == 0)
                take_burst <= !take_burst;
            take_hold <= hold;
            m_ready   <= (hold == 0);
        end else if (take_hold != 0) begin
            take_hold <= take_hold - 1;
            m_ready   <= (take_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration access
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            fipv_pkg::REG_HEADER_MAGIC:  live_cfg.header_magic     = value[7:0];
            fipv_pkg::REG_CHECKSUM_SEED: live_cfg.checksum_seed    = value[7:0];
            fipv_pkg::REG_CODE_BASE:     live_cfg.code_region_base = value;
            fipv_pkg::REG_DATA_BASE:     live_cfg.data_region_base = value;
            default: ;
        endcase
    endtask

    // prdata is taken mid-way through the access cycle
    task automatic apb_readback(input logic [1:0] idx, input logic [31:0] want,
                                input string name);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        compare_field(name, prdata, want);
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Image generation
    // ------------------------------------------------------------------------
    task automatic add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            image_draft.push_back(w[8*i +: 8]);
    endtask

    task automatic add_file_header(input logic [7:0] count);
        image_draft.push_back(live_cfg.header_magic);
        image_draft.push_back(count);
        image_draft.push_back(8'h00);
        image_draft.push_back(8'h00);
        add_word($urandom);
    endtask

    // addresses cluster on the class boundaries
    function automatic logic [31:0] pick_load_address();
        case ($urandom_range(0, 5))
            0:       return live_cfg.code_region_base;
            1:       return live_cfg.code_region_base - 32'd1;
            2:       return live_cfg.data_region_base;
            3:       return live_cfg.data_region_base - 32'd1;
            4:       return live_cfg.code_region_base + 32'($urandom_range(1, 4095));
            default: return $urandom;
        endcase
    endfunction

    // hand the draft to the driver, with optional ignored beats, then the end marker
    task automatic send_draft(input int unsigned ignored_beats);
        fipv_pkg::in_beat_t beat;
        foreach (image_draft[i]) begin
            beat.byte_value   = image_draft[i];
            beat.end_of_image = 1'b0;
            image_bytes.push_back(beat);
        end
        items_queued += image_draft.size() + 1;
        repeat (ignored_beats) begin
            beat.byte_value   = 8'($urandom);
            beat.end_of_image = 1'b0;
            image_bytes.push_back(beat);
        end
        beat.byte_value   = 8'($urandom);
        beat.end_of_image = 1'b1;
        image_bytes.push_back(beat);
        image_draft.delete();
        images_queued++;
    endtask

    task automatic queue_image();
        logic [7:0]  csum, stored, b;
        logic [31:0] len;
        int unsigned pick, nsec, cut, n;
        bit          fit, reaches_status;
        reaches_status = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            // broken file header
            case ($urandom_range(0, 2))
                0: image_draft.push_back(live_cfg.header_magic ^ 8'($urandom_range(1, 255)));
                1: begin
                    image_draft.push_back(live_cfg.header_magic);
                    image_draft.push_back(8'h00);
                end
                default: begin
                    image_draft.push_back(live_cfg.header_magic);
                    image_draft.push_back(8'($urandom_range(1, 255)));
                    if ($urandom_range(0, 1))
                        image_draft.push_back(8'h00);
                    image_draft.push_back(8'($urandom_range(1, 255)));
                end
            endcase
        end else if (pick < 18) begin
            // noise
            reaches_status = 1'b0;
            repeat ($urandom_range(1, 12))
                image_draft.push_back(8'($urandom));
        end else if (pick < 26) begin
            // section far longer than the stream, cut off by the end marker
            reaches_status = 1'b0;
            add_file_header(8'($urandom_range(1, 255)));
            add_word(pick_load_address());
            add_word($urandom_range(32'hFFFF_FFFF, 32'd32));
            repeat ($urandom_range(0, 16))
                image_draft.push_back(8'($urandom));
        end else begin
            // well-formed image with random content
            nsec = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
            fit  = ($urandom_range(0, 3) == 0);
            add_file_header(8'(nsec));
            csum = live_cfg.checksum_seed;
            for (int i = 0; i < nsec; i++) begin
                add_word(pick_load_address());
                len = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
                // last data byte lands just before the final byte of a slot, which holds the checksum
                if (fit && i == nsec - 1)
                    len = 32'(TRAILER_SLOT - 1) - 32'((image_draft.size() + 4) % TRAILER_SLOT);
                add_word(len);
                for (n = 0; n < len; n++) begin
                    b = 8'($urandom);
                    csum ^= b;
                    image_draft.push_back(b);
                end
            end
            n = (TRAILER_SLOT - 1) - (image_draft.size() % TRAILER_SLOT);
            repeat (n)
                image_draft.push_back(8'($urandom));
            stored = csum;
            pick   = $urandom_range(0, 99);
            if (pick < 12)
                stored = csum ^ 8'($urandom_range(1, 255));
            image_draft.push_back(stored);
            if (pick >= 12 && pick < 30) begin
                reaches_status = 1'b0;
                cut = $urandom_range(0, image_draft.size() - 1);
                while (image_draft.size() > cut)
                    void'(image_draft.pop_back());
            end
        end
        send_draft((reaches_status && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
    endtask

    // all beats sent and all records back, then a settling wait for a silent byte
    task automatic wait_idle();
        while (image_bytes.size() != 0 || s_valid)
            @(negedge aclk);
        while (expected_records.size() != 0)
            @(negedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : sequencer
        fipv_pkg::cfg_t plan [NUM_SETTINGS];
        int unsigned    first_item;

        plan[0] = {fipv_pkg::HEADER_MAGIC_RST, fipv_pkg::CHECKSUM_SEED_RST,
                   fipv_pkg::CODE_BASE_RST, fipv_pkg::DATA_BASE_RST};
        plan[1] = {8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000};
        plan[2] = {8'hFF, 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF};
        plan[3] = {8'($urandom), 8'($urandom), 32'h4000_0000, 32'h8000_0000};
        plan[4] = {8'($urandom), 8'($urandom), 32'($urandom), 32'($urandom)};
        plan[5] = plan[0];

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: lone end marker, each header fault, truncation mid-header
        send_draft(0);
        image_draft = '{fipv_pkg::HEADER_MAGIC_RST ^ 8'hFF};
        send_draft(2);
        image_draft = '{fipv_pkg::HEADER_MAGIC_RST, 8'h00};
        send_draft(0);
        image_draft = '{fipv_pkg::HEADER_MAGIC_RST, 8'h01, 8'h80};
        send_draft(0);
        image_draft = '{fipv_pkg::HEADER_MAGIC_RST, 8'hFF, 8'h00, 8'h01};
        send_draft(0);
        image_draft = '{fipv_pkg::HEADER_MAGIC_RST, 8'h03, 8'h00, 8'h00, 8'hFF};
        send_draft(0);
        wait_idle();

        // random batches, one per register setting
        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            if (ph != 0) begin
                apb_write(fipv_pkg::REG_HEADER_MAGIC,  32'(plan[ph].header_magic));
                apb_write(fipv_pkg::REG_CHECKSUM_SEED, 32'(plan[ph].checksum_seed));
                apb_write(fipv_pkg::REG_CODE_BASE,     plan[ph].code_region_base);
                apb_write(fipv_pkg::REG_DATA_BASE,     plan[ph].data_region_base);
            end
            apb_readback(fipv_pkg::REG_HEADER_MAGIC, 32'(live_cfg.header_magic),
                         "header_magic readback");
            apb_readback(fipv_pkg::REG_CHECKSUM_SEED, 32'(live_cfg.checksum_seed),
                         "checksum_seed readback");
            apb_readback(fipv_pkg::REG_CODE_BASE, live_cfg.code_region_base,
                         "code_region_base readback");
            apb_readback(fipv_pkg::REG_DATA_BASE, live_cfg.data_region_base,
                         "data_region_base readback");
            first_item = items_queued;
            while (items_queued - first_item < BEATS_PER_SETTING)
                queue_image();
            wait_idle();
        end

        repeat (IDLE_SETTLE) @(posedge aclk);
        if (expected_records.size() != 0)
            report_mismatch($sformatf("%0d expected records never arrived",
                                      expected_records.size()));

        $display("Run covered %0d images (%0d beats) over %0d register settings.",
                 images_queued, items_queued, NUM_SETTINGS);
        $display("Checked %0d section and %0d status records; %s %0d/%0d/%0d/%0d/%0d/%0d.",
                 sections_checked, statuses_checked, "ok/magic/count/pad/csum/trunc",
                 status_hits[fipv_pkg::ST_OK], status_hits[fipv_pkg::ST_BAD_MAGIC],
                 status_hits[fipv_pkg::ST_NO_SECT], status_hits[fipv_pkg::ST_BAD_PAD],
                 status_hits[fipv_pkg::ST_BAD_CSUM], status_hits[fipv_pkg::ST_TRUNC]);
        if (mismatches == 0) begin
            $display("** firmware_image_parse_verify: PASSED **");
        end else begin
            $display("** firmware_image_parse_verify: FAILED **");
        end
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("Run limit reached with %0d beats and %0d records outstanding.",
                 image_bytes.size(), expected_records.size());
        $display("** firmware_image_parse_verify: FAILED **");
        $finish;
    end

endmodule

// ===== firmware_image_parse_verify.f =====
src/fipv_pkg.sv
src/fipv_cfg_regs.sv
src/fipv_parse_core.sv
src/firmware_image_parse_verify.sv
verif/firmware_image_parse_verify_tb.sv
